>>> rtl/core/lfcu_pkg.sv
// shared types and constants for the liquid fraction cell update
`default_nettype none
package lfcu_pkg;

  localparam logic [1:0] PHASE_SOLID  = 2'd0;
  localparam logic [1:0] PHASE_LIQUID = 2'd1;
  localparam logic [1:0] PHASE_MUSHY  = 2'd2;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SOLIDUS   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LIQUIDUS  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_RANGE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEEP     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EPSILON   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOLID_FRC = 3'd6;

  localparam logic [31:0] GAIN_RESET      = 32'd104857600;
  localparam logic [47:0] EPSILON_RESET   = 48'd281474976711;
  localparam logic [47:0] SOLID_FRC_RESET = 48'd104857600000;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] solidus_temp;
    logic [31:0] liquidus_temp;
    logic [31:0] inverse_range;
    logic [47:0] steep_coef;
    logic [31:0] forcing_gain;
    logic [47:0] forcing_epsilon;
    logic [47:0] solid_forcing;
  } lfcu_cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/lfcu_if.sv
// request channels for cells in and cell results out
`default_nettype none
interface lfcu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature;
  logic [31:0] cell_volume;
  logic        last_cell;

  modport source (output valid, temperature, cell_volume, last_cell, input ready);
  modport sink (input valid, temperature, cell_volume, last_cell, output ready);
endinterface

interface lfcu_out_if #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            phase_state;
  logic [FRAC_BITS:0]    melt_frac;
  logic [47:0]           reaction_coef;
  logic [63:0]           heat_source;
  logic [47:0]           momentum_forcing;
  logic [COUNT_BITS-1:0] solid_count;
  logic [COUNT_BITS-1:0] liquid_cells;
  logic [COUNT_BITS-1:0] mushy_cells;
  logic [47:0]           solid_volume;
  logic [47:0]           liquid_volume;
  logic [47:0]           mushy_volume;

  modport source (output valid, phase_state, melt_frac, reaction_coef, heat_source,
                  momentum_forcing, solid_count, liquid_cells, mushy_cells, solid_volume,
                  liquid_volume, mushy_volume, input ready);
  modport sink (input valid, phase_state, melt_frac, reaction_coef, heat_source,
                momentum_forcing, solid_count, liquid_cells, mushy_cells, solid_volume,
                liquid_volume, mushy_volume, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lfcu_front.sv
// front end: classifies cells, computes the fraction and keeps the sweep tallies
`default_nettype none
module lfcu_front #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  lfcu_in_if.sink                 in_ch,
  input  lfcu_pkg::lfcu_cfg_t     cfg,
  input  wire                     push_ready,
  output logic                    push,
  output logic [1:0]              f_phase,
  output logic                    f_neg,
  output logic [31:0]             f_mag,
  output logic [31:0]             f_vol,
  output logic [FRAC_BITS:0]      f_frac,
  output logic [COUNT_BITS-1:0]   f_solid_cnt,
  output logic [COUNT_BITS-1:0]   f_liquid_cnt,
  output logic [COUNT_BITS-1:0]   f_mushy_cnt,
  output logic [47:0]             f_solid_vol,
  output logic [47:0]             f_liquid_vol,
  output logic [47:0]             f_mushy_vol
);

  localparam logic [FRAC_BITS:0]    FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] solid_tally, liquid_tally, mushy_tally;
  logic [47:0]           solid_vol_sum, liquid_vol_sum, mushy_vol_sum;

  logic                  is_solid, is_liquid;
  logic [31:0]           diff;
  logic [63:0]           prod, g_raw;
  logic [FRAC_BITS:0]    g_sat;
  logic [COUNT_BITS-1:0] cnt_in, cnt_inc;
  logic [47:0]           vol_in;
  logic [48:0]           vol_add;
  logic [47:0]           vol_inc;

  assign in_ch.ready = push_ready;
  assign push        = in_ch.valid & push_ready;

  assign is_solid  = $signed(in_ch.temperature) < $signed(cfg.solidus_temp);
  assign is_liquid = !is_solid && ($signed(in_ch.temperature) > $signed(cfg.liquidus_temp));

  // t >= solidus in the mushy band, so the wrapped difference is exact
  assign diff  = in_ch.temperature - cfg.solidus_temp;
  assign prod  = {32'b0, diff} * {32'b0, cfg.inverse_range};
  assign g_raw = prod >> (32 - FRAC_BITS);
  assign g_sat = (g_raw > {{(63 - FRAC_BITS){1'b0}}, FRAC_ONE}) ? FRAC_ONE
                                                                : g_raw[FRAC_BITS:0];

  always_comb begin
    if (is_solid) begin
      f_phase = lfcu_pkg::PHASE_SOLID;
      f_frac  = '0;
      cnt_in  = solid_tally;
      vol_in  = solid_vol_sum;
    end else if (is_liquid) begin
      f_phase = lfcu_pkg::PHASE_LIQUID;
      f_frac  = FRAC_ONE;
      cnt_in  = liquid_tally;
      vol_in  = liquid_vol_sum;
    end else begin
      f_phase = lfcu_pkg::PHASE_MUSHY;
      f_frac  = g_sat;
      cnt_in  = mushy_tally;
      vol_in  = mushy_vol_sum;
    end
  end

  assign cnt_inc = (cnt_in == COUNT_MAX) ? cnt_in : cnt_in + 1'b1;
  assign vol_add = {1'b0, vol_in} + {17'b0, in_ch.cell_volume};
  assign vol_inc = vol_add[48] ? lfcu_pkg::MAX48 : vol_add[47:0];

  assign f_neg = in_ch.temperature[31];
  assign f_mag = in_ch.temperature[31] ? (~in_ch.temperature + 32'd1) : in_ch.temperature;
  assign f_vol = in_ch.cell_volume;

  assign f_solid_cnt  = is_solid ? cnt_inc : solid_tally;
  assign f_liquid_cnt = is_liquid ? cnt_inc : liquid_tally;
  assign f_mushy_cnt  = (!is_solid && !is_liquid) ? cnt_inc : mushy_tally;
  assign f_solid_vol  = is_solid ? vol_inc : solid_vol_sum;
  assign f_liquid_vol = is_liquid ? vol_inc : liquid_vol_sum;
  assign f_mushy_vol  = (!is_solid && !is_liquid) ? vol_inc : mushy_vol_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      solid_tally    <= '0;
      liquid_tally   <= '0;
      mushy_tally    <= '0;
      solid_vol_sum  <= '0;
      liquid_vol_sum <= '0;
      mushy_vol_sum  <= '0;
    end else if (push) begin
      if (in_ch.last_cell) begin
        solid_tally    <= '0;
        liquid_tally   <= '0;
        mushy_tally    <= '0;
        solid_vol_sum  <= '0;
        liquid_vol_sum <= '0;
        mushy_vol_sum  <= '0;
      end else begin
        solid_tally    <= f_solid_cnt;
        liquid_tally   <= f_liquid_cnt;
        mushy_tally    <= f_mushy_cnt;
        solid_vol_sum  <= f_solid_vol;
        liquid_vol_sum <= f_liquid_vol;
        mushy_vol_sum  <= f_mushy_vol;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lfcu_queue.sv
// two-entry queue between front and back end
`default_nettype none
module lfcu_queue #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  output logic             push_ready,
  input  wire              pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lfcu_back.sv
// back end: heat source and momentum forcing on a shared multiplier and a serial divider
`default_nettype none
module lfcu_back #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  lfcu_pkg::lfcu_cfg_t     cfg,
  input  wire                     pop_valid,
  output logic                    pop,
  input  wire [1:0]               b_phase,
  input  wire                     b_neg,
  input  wire [31:0]              b_mag,
  input  wire [31:0]              b_vol,
  input  wire [FRAC_BITS:0]       b_frac,
  input  wire [COUNT_BITS-1:0]    b_solid_cnt,
  input  wire [COUNT_BITS-1:0]    b_liquid_cnt,
  input  wire [COUNT_BITS-1:0]    b_mushy_cnt,
  input  wire [47:0]              b_solid_vol,
  input  wire [47:0]              b_liquid_vol,
  input  wire [47:0]              b_mushy_vol,
  lfcu_out_if.source              out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] OP_MAG_VOL = 3'd0;
  localparam logic [2:0] OP_STEEP   = 3'd1;
  localparam logic [2:0] OP_G_SQ    = 3'd2;
  localparam logic [2:0] OP_G_CUBE  = 3'd3;
  localparam logic [2:0] OP_OMG_SQ  = 3'd4;
  localparam logic [2:0] OP_NUMER   = 3'd5;

  localparam logic [1:0] CHUNK_LAST = 2'd2;
  localparam int         QBITS      = 48;
  localparam logic [5:0] DCNT_LAST  = 6'(QBITS - 1);
  localparam int         G3_SHIFT   = 3 * FRAC_BITS - 48;
  localparam int         G3_R       = (G3_SHIFT > 0) ? G3_SHIFT : 0;
  localparam int         G3_L       = (G3_SHIFT < 0) ? -G3_SHIFT : 0;
  localparam int         NUM_SHIFT  = 48 - 2 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [1:0]            state;
  logic [2:0]            op;
  logic [1:0]            chunk;
  logic [111:0]          acc;

  logic [1:0]            it_phase;
  logic                  it_neg;
  logic [31:0]           it_mag, it_vol;
  logic [FRAC_BITS:0]    it_frac;
  logic [COUNT_BITS-1:0] it_solid_cnt, it_liquid_cnt, it_mushy_cnt;
  logic [47:0]           it_solid_vol, it_liquid_vol, it_mushy_vol;

  logic [63:0]           mv, gg, msq;
  logic [49:0]           den;
  logic [49:0]           rem;
  logic [47:0]           nsh, quo;
  logic [5:0]            dcnt;
  logic [63:0]           heat;
  logic [47:0]           force_val;

  logic                  ov;
  logic [1:0]            o_phase;
  logic [FRAC_BITS:0]    o_frac;
  logic [47:0]           o_react;
  logic [63:0]           o_heat;
  logic [47:0]           o_force;
  logic [COUNT_BITS-1:0] o_solid_cnt, o_liquid_cnt, o_mushy_cnt;
  logic [47:0]           o_solid_vol, o_liquid_vol, o_mushy_vol;

  logic [63:0]           a_op;
  logic [47:0]           b_op;
  logic [15:0]           b_chunk;
  logic [79:0]           pp;
  logic [111:0]          pp_sh, acc_sum, g3_sh;
  logic [FRAC_BITS:0]    omg;
  logic [63:0]           hmag, heat_new;
  logic [49:0]           den_new;
  logic [79:0]           num;
  logic [50:0]           rem2;
  logic                  ge;
  logic                  slot_free;

  assign omg = FRAC_ONE - it_frac;

  always_comb begin
    case (op)
      OP_MAG_VOL: begin
        a_op = {32'b0, it_mag};
        b_op = {16'b0, it_vol};
      end
      OP_STEEP: begin
        a_op = mv;
        b_op = cfg.steep_coef;
      end
      OP_G_SQ: begin
        a_op = 64'(it_frac);
        b_op = 48'(it_frac);
      end
      OP_G_CUBE: begin
        a_op = gg;
        b_op = 48'(it_frac);
      end
      OP_OMG_SQ: begin
        a_op = 64'(omg);
        b_op = 48'(omg);
      end
      OP_NUMER: begin
        a_op = msq << NUM_SHIFT;
        b_op = {16'b0, cfg.forcing_gain};
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // one 64x16 partial product per cycle, three per multiplication
  assign b_chunk = b_op[{chunk, 4'b0} +: 16];
  assign pp      = {16'b0, a_op} * {64'b0, b_chunk};
  assign pp_sh   = {32'b0, pp} << {chunk, 4'b0};
  assign acc_sum = ((chunk == 2'd0) ? 112'b0 : acc) + pp_sh;

  assign hmag = acc_sum[111:48];
  always_comb begin
    if (!it_neg) begin
      heat_new = hmag[63] ? 64'h7FFF_FFFF_FFFF_FFFF : hmag;
    end else begin
      heat_new = (hmag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : (~hmag + 64'd1);
    end
  end

  assign g3_sh   = (acc_sum >> G3_R) << G3_L;
  assign den_new = g3_sh[49:0] + {2'b0, cfg.forcing_epsilon};
  assign num     = acc_sum[79:0];

  assign rem2 = {rem, nsh[47]};
  assign ge   = rem2 >= {1'b0, den};

  assign slot_free = !ov || out_ch.ready;
  assign pop       = (state == ST_IDLE) && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_MAG_VOL;
      chunk <= 2'd0;
      dcnt  <= 6'd0;
      ov    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            op    <= OP_MAG_VOL;
            chunk <= 2'd0;
            state <= (b_phase == lfcu_pkg::PHASE_MUSHY) ? ST_MUL : ST_DONE;
          end
        end
        ST_MUL: begin
          if (chunk == CHUNK_LAST) begin
            chunk <= 2'd0;
            op    <= op + 3'd1;
            if (op == OP_NUMER) begin
              dcnt  <= 6'd0;
              state <= ({18'b0, num[79:48]} >= den) ? ST_DONE : ST_DIV;
            end
          end else begin
            chunk <= chunk + 2'd1;
          end
        end
        ST_DIV: begin
          dcnt <= dcnt + 6'd1;
          if (dcnt == DCNT_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if ((state == ST_DONE) && slot_free) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          it_phase      <= b_phase;
          it_neg        <= b_neg;
          it_mag        <= b_mag;
          it_vol        <= b_vol;
          it_frac       <= b_frac;
          it_solid_cnt  <= b_solid_cnt;
          it_liquid_cnt <= b_liquid_cnt;
          it_mushy_cnt  <= b_mushy_cnt;
          it_solid_vol  <= b_solid_vol;
          it_liquid_vol <= b_liquid_vol;
          it_mushy_vol  <= b_mushy_vol;
          heat          <= '0;
          force_val     <= (b_phase == lfcu_pkg::PHASE_SOLID) ? cfg.solid_forcing : 48'd0;
        end
      end
      ST_MUL: begin
        acc <= acc_sum;
        if (chunk == CHUNK_LAST) begin
          case (op)
            OP_MAG_VOL: mv <= acc_sum[63:0];
            OP_STEEP:   heat <= heat_new;
            OP_G_SQ:    gg <= acc_sum[63:0];
            OP_G_CUBE:  den <= den_new;
            OP_OMG_SQ:  msq <= acc_sum[63:0];
            OP_NUMER: begin
              // quotient would not fit in 48 bits, also covers a zero denominator
              force_val <= lfcu_pkg::MAX48;
              rem       <= {18'b0, num[79:48]};
              nsh       <= num[47:0];
              quo       <= '0;
            end
            default: mv <= mv;
          endcase
        end
      end
      ST_DIV: begin
        rem <= ge ? 50'(rem2 - {1'b0, den}) : rem2[49:0];
        nsh <= {nsh[46:0], 1'b0};
        quo <= {quo[46:0], ge};
        if (dcnt == DCNT_LAST) begin
          force_val <= {quo[46:0], ge};
        end
      end
      default: begin
      end
    endcase
    if ((state == ST_DONE) && slot_free) begin
      o_phase      <= it_phase;
      o_frac       <= it_frac;
      o_react      <= (it_phase == lfcu_pkg::PHASE_MUSHY) ? cfg.steep_coef : 48'd0;
      o_heat       <= heat;
      o_force      <= force_val;
      o_solid_cnt  <= it_solid_cnt;
      o_liquid_cnt <= it_liquid_cnt;
      o_mushy_cnt  <= it_mushy_cnt;
      o_solid_vol  <= it_solid_vol;
      o_liquid_vol <= it_liquid_vol;
      o_mushy_vol  <= it_mushy_vol;
    end
  end

  assign out_ch.valid            = ov;
  assign out_ch.phase_state      = o_phase;
  assign out_ch.melt_frac        = o_frac;
  assign out_ch.reaction_coef    = o_react;
  assign out_ch.heat_source      = o_heat;
  assign out_ch.momentum_forcing = o_force;
  assign out_ch.solid_count      = o_solid_cnt;
  assign out_ch.liquid_cells     = o_liquid_cnt;
  assign out_ch.mushy_cells      = o_mushy_cnt;
  assign out_ch.solid_volume     = o_solid_vol;
  assign out_ch.liquid_volume    = o_liquid_vol;
  assign out_ch.mushy_volume     = o_mushy_vol;

endmodule
`default_nettype wire

>>> rtl/core/liquid_fraction_cell_update.sv
// top level of the liquid fraction cell update
//
//   channel   dir  contents
//   in_ch     in   temperature, cell_volume, last_cell
//   out_ch    out  phase, fraction, reaction, heat, forcing, counts, volumes
//   cfg_*     in   register write: cfg_write, cfg_index, cfg_data
//
// solid and liquid cells go from taking the request straight to handing the result over;
// mushy cells run six products on the shared 64x16 multiplier, then the bit-serial
// divider, before the hand-over; a saturating quotient skips the divider.
// the front end classifies and tallies a cell in the cycle it is taken and a two-entry
// queue lets it run ahead of the back end.
// rst is synchronous, clears tallies, queue and sequencer and loads the register file defaults.
// the output register holds a result while the back end starts the next cell.
`default_nettype none
module liquid_fraction_cell_update #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     cfg_write,
  input  wire [lfcu_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  wire [lfcu_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  lfcu_in_if.sink                                 in_ch,
  lfcu_out_if.source                              out_ch
);

  localparam int QW = 2 + 1 + 32 + 32 + (FRAC_BITS + 1) + 3 * COUNT_BITS + 3 * 48;

  lfcu_pkg::lfcu_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.solidus_temp    <= '0;
      cfg.liquidus_temp   <= '0;
      cfg.inverse_range   <= '0;
      cfg.steep_coef      <= '0;
      cfg.forcing_gain    <= lfcu_pkg::GAIN_RESET;
      cfg.forcing_epsilon <= lfcu_pkg::EPSILON_RESET;
      cfg.solid_forcing   <= lfcu_pkg::SOLID_FRC_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lfcu_pkg::REG_SOLIDUS:   cfg.solidus_temp    <= cfg_data[31:0];
        lfcu_pkg::REG_LIQUIDUS:  cfg.liquidus_temp   <= cfg_data[31:0];
        lfcu_pkg::REG_INV_RANGE: cfg.inverse_range   <= cfg_data[31:0];
        lfcu_pkg::REG_STEEP:     cfg.steep_coef      <= cfg_data;
        lfcu_pkg::REG_GAIN:      cfg.forcing_gain    <= cfg_data[31:0];
        lfcu_pkg::REG_EPSILON:   cfg.forcing_epsilon <= cfg_data;
        lfcu_pkg::REG_SOLID_FRC: cfg.solid_forcing   <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  logic                  push, push_ready, pop, pop_valid;
  logic [QW-1:0]         push_data, pop_data;
  logic [1:0]            f_phase, b_phase;
  logic                  f_neg, b_neg;
  logic [31:0]           f_mag, f_vol, b_mag, b_vol;
  logic [FRAC_BITS:0]    f_frac, b_frac;
  logic [COUNT_BITS-1:0] f_sc, f_lc, f_mc, b_sc, b_lc, b_mc;
  logic [47:0]           f_sv, f_lv, f_mv, b_sv, b_lv, b_mv;

  lfcu_front #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .in_ch, .cfg, .push_ready, .push,
    .f_phase, .f_neg, .f_mag, .f_vol, .f_frac,
    .f_solid_cnt(f_sc), .f_liquid_cnt(f_lc), .f_mushy_cnt(f_mc),
    .f_solid_vol(f_sv), .f_liquid_vol(f_lv), .f_mushy_vol(f_mv)
  );

  assign push_data = {f_phase, f_neg, f_mag, f_vol, f_frac, f_sc, f_lc, f_mc, f_sv, f_lv, f_mv};

  lfcu_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst, .push, .push_data, .push_ready, .pop, .pop_valid, .pop_data
  );

  assign {b_phase, b_neg, b_mag, b_vol, b_frac, b_sc, b_lc, b_mc, b_sv, b_lv, b_mv} = pop_data;

  lfcu_back #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .cfg, .pop_valid, .pop,
    .b_phase, .b_neg, .b_mag, .b_vol, .b_frac,
    .b_solid_cnt(b_sc), .b_liquid_cnt(b_lc), .b_mushy_cnt(b_mc),
    .b_solid_vol(b_sv), .b_liquid_vol(b_lv), .b_mushy_vol(b_mv),
    .out_ch
  );

endmodule
`default_nettype wire

>>> tb/liquid_fraction_cell_update_test.sv
// testbench for liquid_fraction_cell_update: random cells against a predictor and scoreboard
`timescale 1ns / 1ps
module liquid_fraction_cell_update_test;

  typedef struct {
    logic [1:0]  phase_state;
    logic [16:0] melt_frac;
    logic [47:0] reaction_coef;
    logic [63:0] heat_source;
    logic [47:0] momentum_forcing;
    logic [23:0] solid_count;
    logic [23:0] liquid_cells;
    logic [23:0] mushy_cells;
    logic [47:0] solid_volume;
    logic [47:0] liquid_volume;
    logic [47:0] mushy_volume;
  } cell_result_t;

  class phase_scoreboard;
    logic [31:0] solidus, liquidus, inv_range, gain;
    logic [47:0] steep, eps, solid_frc;
    logic [23:0] n_solid, n_liquid, n_mushy;
    logic [47:0] v_solid, v_liquid, v_mushy;
    cell_result_t pending[$];
    int errors, checked;
    int seen[3];

    function new();
      solidus = 0; liquidus = 0; inv_range = 0; steep = 0;
      gain = lfcu_pkg::GAIN_RESET; eps = lfcu_pkg::EPSILON_RESET;
      solid_frc = lfcu_pkg::SOLID_FRC_RESET;
      clear_sums();
      errors = 0; checked = 0;
      seen[0] = 0; seen[1] = 0; seen[2] = 0;
    endfunction

    function void clear_sums();
      n_solid = 0; n_liquid = 0; n_mushy = 0;
      v_solid = 0; v_liquid = 0; v_mushy = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] d);
      case (idx)
        lfcu_pkg::REG_SOLIDUS:   solidus = d[31:0];
        lfcu_pkg::REG_LIQUIDUS:  liquidus = d[31:0];
        lfcu_pkg::REG_INV_RANGE: inv_range = d[31:0];
        lfcu_pkg::REG_STEEP:     steep = d;
        lfcu_pkg::REG_GAIN:      gain = d[31:0];
        lfcu_pkg::REG_EPSILON:   eps = d;
        lfcu_pkg::REG_SOLID_FRC: solid_frc = d;
        default: ;
      endcase
    endfunction

    function logic [47:0] add_vol(logic [47:0] acc, logic [31:0] vol);
      logic [48:0] s;
      s = {1'b0, acc} + vol;
      return s[48] ? lfcu_pkg::MAX48 : s[47:0];
    endfunction

    function logic [23:0] add_one(logic [23:0] c);
      return (c == 24'hFF_FFFF) ? c : c + 24'd1;
    endfunction

    function void note_cell(logic [31:0] temp, logic [31:0] vol, logic last);
      cell_result_t r;
      logic [63:0] diff, g, hmag;
      logic [31:0] mag;
      logic [127:0] prod, num, q;
      logic [63:0] den;
      r.phase_state = lfcu_pkg::PHASE_MUSHY; r.melt_frac = 0; r.reaction_coef = 0;
      r.heat_source = 0; r.momentum_forcing = 0;
      if ($signed(temp) < $signed(solidus)) begin
        r.phase_state = lfcu_pkg::PHASE_SOLID;
        r.momentum_forcing = solid_frc;
        n_solid = add_one(n_solid);
        v_solid = add_vol(v_solid, vol);
      end else if ($signed(temp) > $signed(liquidus)) begin
        r.phase_state = lfcu_pkg::PHASE_LIQUID;
        r.melt_frac = 17'h10000;
        n_liquid = add_one(n_liquid);
        v_liquid = add_vol(v_liquid, vol);
      end else begin
        diff = {{32{temp[31]}}, temp} - {{32{solidus[31]}}, solidus};
        g = (diff * {32'd0, inv_range}) >> 16;
        if (g > 64'h10000) g = 64'h10000;
        r.melt_frac = g[16:0];
        r.reaction_coef = steep;
        // exact |T| * steep * vol, truncated to 16 fraction bits
        mag = temp[31] ? -temp : temp;
        prod = {80'd0, steep} * {96'd0, mag} * {96'd0, vol};
        hmag = prod[111:48];
        if (!temp[31])
          r.heat_source = (hmag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : hmag;
        else
          r.heat_source = (hmag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -hmag;
        // penalty gain*(1-g)^2/(g^3+eps): (1-g)^2 and g^3+eps in Q.48, the quotient takes the scale of gain
        den = g * g * g + {16'd0, eps};
        num = (({64'd0, 64'h10000 - g} * {64'd0, 64'h10000 - g}) << 16) * {96'd0, gain};
        if (den == 0) r.momentum_forcing = lfcu_pkg::MAX48;
        else begin
          q = num / {64'd0, den};
          r.momentum_forcing = (q > {80'd0, lfcu_pkg::MAX48}) ? lfcu_pkg::MAX48 : q[47:0];
        end
        n_mushy = add_one(n_mushy);
        v_mushy = add_vol(v_mushy, vol);
      end
      r.solid_count = n_solid; r.liquid_cells = n_liquid; r.mushy_cells = n_mushy;
      r.solid_volume = v_solid; r.liquid_volume = v_liquid; r.mushy_volume = v_mushy;
      pending.push_back(r);
      if (last) clear_sums();
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      end
    endfunction

    function void check_result(cell_result_t a);
      cell_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual phase %0d", $time,
                 a.phase_state);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.phase_state <= 2) seen[e.phase_state]++;
      cmp("phase_state", e.phase_state, a.phase_state);
      cmp("melt_frac", e.melt_frac, a.melt_frac);
      cmp("reaction_coef", e.reaction_coef, a.reaction_coef);
      cmp("heat_source", e.heat_source, a.heat_source);
      cmp("momentum_forcing", e.momentum_forcing, a.momentum_forcing);
      cmp("solid_count", e.solid_count, a.solid_count);
      cmp("liquid_cells", e.liquid_cells, a.liquid_cells);
      cmp("mushy_cells", e.mushy_cells, a.mushy_cells);
      cmp("solid_volume", e.solid_volume, a.solid_volume);
      cmp("liquid_volume", e.liquid_volume, a.liquid_volume);
      cmp("mushy_volume", e.mushy_volume, a.mushy_volume);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [lfcu_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [lfcu_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  lfcu_in_if in_ch();
  lfcu_out_if #(.COUNT_BITS(24), .FRAC_BITS(16)) out_ch();

  liquid_fraction_cell_update #(.COUNT_BITS(24), .FRAC_BITS(16)) u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  phase_scoreboard sb = new();
  bit calm = 1'b0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int stall_left = 0;
  int cells_sent = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.temperature = '0;
    in_ch.cell_volume = '0;
    in_ch.last_cell = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side: random stalls plus one long hold when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{out_ch.phase_state, out_ch.melt_frac, out_ch.reaction_coef,
          out_ch.heat_source, out_ch.momentum_forcing, out_ch.solid_count,
          out_ch.liquid_cells, out_ch.mushy_cells, out_ch.solid_volume,
          out_ch.liquid_volume, out_ch.mushy_volume});
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_done != hold_asked) begin
        hold_done <= hold_asked;
        hold_left <= 400;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_cell(logic [31:0] temp, logic [31:0] vol, logic last);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.temperature <= temp;
    in_ch.cell_volume <= vol;
    in_ch.last_cell <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_cell(temp, vol, last);
    cells_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] s, logic [31:0] l, logic [31:0] inv,
                           logic [47:0] st, logic [31:0] gn, logic [47:0] ep,
                           logic [47:0] sf);
    logic [47:0] vals[7];
    logic [2:0] idx[7];
    vals = '{{16'd0, s}, {16'd0, l}, {16'd0, inv}, st, {16'd0, gn}, ep, sf};
    idx = '{lfcu_pkg::REG_SOLIDUS, lfcu_pkg::REG_LIQUIDUS, lfcu_pkg::REG_INV_RANGE,
            lfcu_pkg::REG_STEEP, lfcu_pkg::REG_GAIN, lfcu_pkg::REG_EPSILON,
            lfcu_pkg::REG_SOLID_FRC};
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom_range(16'hFFFF), $urandom()} & lfcu_pkg::MAX48;
  endfunction

  // mostly near the mushy band, some anywhere, some right on the edges
  function automatic logic [31:0] pick_temp();
    longint s, l, w, t;
    int r;
    s = $signed(sb.solidus);
    l = $signed(sb.liquidus);
    r = $urandom_range(99);
    if (r < 10) return $urandom();
    if (r < 15) return sb.solidus + $urandom_range(1) - 1;
    if (r < 20) return sb.liquidus + $urandom_range(1);
    w = (l > s) ? l - s : 64'd65536;
    t = s - w / 4 + longint'({$urandom(), $urandom()} % (w + w / 2 + 1));
    if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
    if (t < -64'sh8000_0000) t = -64'sh8000_0000;
    return t[31:0];
  endfunction

  function automatic logic [31:0] pick_vol();
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom();
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom_range(32'h00FF_FFFF);
  endfunction

  task automatic random_cells(int n);
    for (int i = 0; i < n; i++) begin
      send_cell(pick_temp(), pick_vol(), $urandom_range(24) == 0);
    end
  endtask

  initial begin
    logic [31:0] s, l, w;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: both limits at zero, only a zero temperature is mushy
    send_cell(32'd0, 32'd1000, 1'b0);
    send_cell(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_cell(32'h7FFF_FFFF, 32'd0, 1'b0);
    send_cell(32'hFFFF_FFFF, 32'd5, 1'b0);
    send_cell(32'd1, 32'd7, 1'b1);
    stop_sending();
    wait_drained();

    // a plausible band from -5 to +10 kelvin with negative mushy temperatures
    load_regs(32'hFFFB_0000, 32'h000A_0000, 32'd4369, rand48(), lfcu_pkg::GAIN_RESET,
              lfcu_pkg::EPSILON_RESET, rand48());
    send_cell(32'hFFFB_0000, 32'd100, 1'b0);
    send_cell(32'h000A_0000, 32'd100, 1'b0);
    send_cell(32'hFFFA_FFFF, 32'd100, 1'b0);
    send_cell(32'h000A_0001, 32'd100, 1'b0);
    send_cell(32'h0002_8000, 32'hFFFF_FFFF, 1'b0);
    send_cell(32'hFFFF_0000, 32'd0, 1'b0);
    send_cell(32'd0, 32'hFFFF_FFFF, 1'b1);
    send_cell(32'h0002_0000, 32'd3, 1'b0);
    random_cells(150);
    // sender waits for every result, then the sink holds off while cells pile up
    stop_sending();
    wait_drained();
    hold_asked <= hold_asked + 1;
    random_cells(150);
    stop_sending();
    wait_drained();

    // everything mushy, every coefficient at its top but epsilon at one: saturating heat and forcing
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, lfcu_pkg::MAX48, 32'hFFFF_FFFF,
              48'd1, lfcu_pkg::MAX48);
    send_cell(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_cell(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_cell(32'h8000_0000, 32'd1, 1'b0);
    send_cell(32'd0, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 200; i++) send_cell($urandom(), $urandom(), $urandom_range(15) == 0);
    stop_sending();
    wait_drained();

    // inverted limits: no mushy cell, all other registers at the other extreme
    calm = 1'b1;
    load_regs(32'h0064_0000, 32'hFF9C_0000, 32'd0, 48'd0, 32'd0, lfcu_pkg::MAX48, 48'd0);
    send_cell(32'h0000_0000, 32'd9, 1'b0);
    send_cell(32'h0064_0000, 32'd9, 1'b0);
    random_cells(140);
    stop_sending();
    wait_drained();
    calm = 1'b0;

    // a run of random bands, gains and guards
    for (int p = 0; p < 6; p++) begin
      s = $urandom() >> $urandom_range(8, 1);
      if ($urandom_range(1)) s = -s;
      w = $urandom_range(32'h00FF_FFFF, 32'h100);
      l = s + w;
      load_regs(s, l, (p == 5) ? $urandom() : 32'(64'h1_0000_0000 / w), rand48(),
                $urandom(), (p == 0) ? 48'd1 : rand48() >> $urandom_range(40),
                rand48());
      calm = (p == 2);
      random_cells(100);
      stop_sending();
      wait_drained();
    end
    calm = 1'b0;

    repeat (100) @(posedge clk);
    $display("cells sent %0d, checked %0d (solid %0d, liquid %0d, mushy %0d)",
             cells_sent, sb.checked, sb.seen[0], sb.seen[1], sb.seen[2]);
    $display("over 10 register sets with output holds and input stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d results missing", sb.errors, sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
